// ===== rtl/rv64c_pkg.sv =====
// Shared types, constants and helpers for the RV64IM instruction core.
// Used by the controller, the datapath and the top level; no dependencies.
package rv64c_pkg;

  // Memory geometry: byte addresses wrap modulo MEM_BYTES (a power of two).
  localparam int MEM_BYTES = 65536;
  localparam int AW        = $clog2(MEM_BYTES);

  localparam int FETCH_BYTES = 4;

  // Request codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP32    = 7'h3B;

  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [5:0] SRAI_HI   = 6'h10;

  localparam logic [2:0] F3_LOAD_RSVD = 3'd7;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WR, S_RD, S_RD2, S_FETCH, S_RS1, S_RS2, S_RS3,
    S_EXEC, S_LOAD, S_LEXT, S_STORE, S_MLOOP, S_MFIX1, S_MFIX2,
    S_DLOOP, S_DFIX, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    C_LUI, C_AUIPC, C_JAL, C_JALR, C_BRANCH, C_LOAD, C_STORE,
    C_ALU, C_MUL, C_DIV, C_ILLEGAL
  } cls_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic mem_wr;
    logic mem_rd;
    logic cap_rbyte;
    logic fetch;
    logic rd_rs1;
    logic rd_rs2;
    logic cap_b;
    logic exec;
    logic load;
    logic load_ext;
    logic store;
    logic mstep;
    logic mfix1;
    logic mfix2;
    logic dstep;
    logic dfix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    cls_t       cls;
    logic [2:0] f3;
    logic [3:0] cnt;
    logic [3:0] nbytes;
    logic       loop_last;
    logic       clr_last;
  } status_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ===== rtl/rv64c_ctrl.sv =====
// Sequencing state machine of the RV64IM instruction core.
// Depends on rv64c_pkg; drives the datapath through cmd_t, reads status_t.
module rv64c_ctrl
  import rv64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  status_t    st,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (req_type)
            REQ_WRITE: state_next = S_WR;
            REQ_READ:  state_next = S_RD;
            REQ_EXEC:  state_next = S_FETCH;
            default:   state_next = S_FIN;
          endcase
        end
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        state_next = S_FIN;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.cap_rbyte = 1'b1;
        state_next    = S_FIN;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (st.cnt == 4'(FETCH_BYTES)) state_next = S_RS1;
      end
      S_RS1: begin
        cmd.rd_rs1 = 1'b1;
        state_next = S_RS2;
      end
      S_RS2: begin
        cmd.rd_rs2 = 1'b1;
        state_next = S_RS3;
      end
      S_RS3: begin
        cmd.cap_b  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.cls)
          C_LOAD:  state_next = (st.f3 == F3_LOAD_RSVD) ? S_FIN : S_LOAD;
          C_STORE: state_next = st.f3[2] ? S_FIN : S_STORE;
          C_MUL:   state_next = S_MLOOP;
          C_DIV:   state_next = S_DLOOP;
          default: state_next = S_FIN;
        endcase
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (st.cnt == st.nbytes) state_next = S_LEXT;
      end
      S_LEXT: begin
        cmd.load_ext = 1'b1;
        state_next   = S_FIN;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (st.cnt == st.nbytes - 4'd1) state_next = S_FIN;
      end
      S_MLOOP: begin
        cmd.mstep = 1'b1;
        if (st.loop_last) state_next = S_MFIX1;
      end
      S_MFIX1: begin
        cmd.mfix1  = 1'b1;
        state_next = S_MFIX2;
      end
      S_MFIX2: begin
        cmd.mfix2  = 1'b1;
        state_next = S_FIN;
      end
      S_DLOOP: begin
        cmd.dstep = 1'b1;
        if (st.loop_last) state_next = S_DFIX;
      end
      S_DFIX: begin
        cmd.dfix   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/rv64c_dp.sv =====
// Datapath of the RV64IM instruction core: byte memory, register file,
// ALU, shift-add multiplier and restoring divider. Depends on rv64c_pkg.
module rv64c_dp
  import rv64c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [7:0]  write_byte,
  output status_t     st,
  output logic        done,
  output logic [7:0]  read_byte,
  output logic [63:0] pc_value,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [63:0] reg_value,
  output logic        opcode_illegal
);

  // Byte memory, one write and one registered read per cycle.
  logic [7:0]    mem [MEM_BYTES];
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  // Register file with per-entry valid bits; an invalid entry reads zero.
  logic [63:0] rf [32];
  logic [31:0] rf_valid;
  logic [63:0] rf_raw;
  logic        rf_v;
  logic [4:0]  rf_raddr;
  logic        rf_we;
  logic [63:0] rf_out;

  logic [1:0]    req_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    wbyte_q;
  logic [AW-1:0] clr;
  logic [63:0]   pc, npc;
  logic [31:0]   ir;
  logic [63:0]   opa, opb, res, acc_hi, acc_lo, dv;
  logic [AW-1:0] ea;
  logic [3:0]    cnt;
  logic [5:0]    lcnt;
  logic          have, illegal;
  logic [7:0]    rbyte;

  // Decode.
  logic [6:0]  op, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic        is_op, is_op32, is_imm, is_imm32, word, md, alt;
  cls_t        cls;

  assign op  = ir[6:0];
  assign rd  = ir[11:7];
  assign f3  = ir[14:12];
  assign rs1 = ir[19:15];
  assign rs2 = ir[24:20];
  assign f7  = ir[31:25];

  assign imm_i = {{52{ir[31]}}, ir[31:20]};
  assign imm_s = {{52{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{51{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_j = {{43{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  assign imm_u = {{32{ir[31]}}, ir[31:12], 12'h000};

  assign is_op    = (op == OPC_OP);
  assign is_op32  = (op == OPC_OP32);
  assign is_imm   = (op == OPC_OPIMM);
  assign is_imm32 = (op == OPC_OPIMM32);
  assign word     = is_op32 || is_imm32;
  assign md       = (is_op || is_op32) && (f7 == F7_MULDIV);

  always_comb begin
    if (is_imm)        alt = (f3 == 3'd5) && (ir[31:26] == SRAI_HI);
    else if (is_imm32) alt = (f3 == 3'd5) && (f7 == F7_ALT);
    else               alt = (f7 == F7_ALT);
  end

  always_comb begin
    unique case (op)
      OPC_LUI:    cls = C_LUI;
      OPC_AUIPC:  cls = C_AUIPC;
      OPC_JAL:    cls = C_JAL;
      OPC_JALR:   cls = C_JALR;
      OPC_BRANCH: cls = C_BRANCH;
      OPC_LOAD:   cls = C_LOAD;
      OPC_STORE:  cls = C_STORE;
      OPC_OPIMM, OPC_OPIMM32: cls = C_ALU;
      OPC_OP, OPC_OP32: cls = md ? (f3[2] ? C_DIV : C_MUL) : C_ALU;
      default:    cls = C_ILLEGAL;
    endcase
  end

  // ALU. Word forms work on the low words and sign-extend the low 32 bits.
  logic [63:0] bsel, x, y, alu_r, alu_w, sra_r;
  logic [5:0]  sh;

  assign bsel = (is_imm || is_imm32) ? imm_i : opb;
  assign x    = word ? ((f3 == 3'd5 && alt) ? sext32(opa[31:0]) : {32'h0, opa[31:0]}) : opa;
  assign y    = word ? {32'h0, bsel[31:0]} : bsel;
  assign sh   = word ? {1'b0, bsel[4:0]} : bsel[5:0];
  assign sra_r = 64'($signed(x) >>> sh);

  always_comb begin
    case (f3)
      3'd0:    alu_w = alt ? x - y : x + y;
      3'd1:    alu_w = x << sh;
      3'd2:    alu_w = {63'h0, $signed(x) < $signed(y)};
      3'd3:    alu_w = {63'h0, x < y};
      3'd4:    alu_w = x ^ y;
      3'd5:    alu_w = alt ? sra_r : x >> sh;
      3'd6:    alu_w = x | y;
      default: alu_w = x & y;
    endcase
    alu_r = word ? sext32(alu_w[31:0]) : alu_w;
  end

  // Branch condition.
  logic taken;
  always_comb begin
    case (f3)
      3'd0:    taken = (opa == opb);
      3'd1:    taken = (opa != opb);
      3'd4:    taken = $signed(opa) < $signed(opb);
      3'd5:    taken = !($signed(opa) < $signed(opb));
      3'd6:    taken = opa < opb;
      3'd7:    taken = opa >= opb;
      default: taken = 1'b0;
    endcase
  end

  // Multiply/divide operands and divider signs.
  logic        sgn_word, dsigned, na, nb;
  logic [63:0] ma, mb, ua, ub;

  assign sgn_word = (f3 == 3'd0) || (f3 == 3'd4) || (f3 == 3'd6);
  assign ma = word ? (sgn_word ? sext32(opa[31:0]) : {32'h0, opa[31:0]}) : opa;
  assign mb = word ? (sgn_word ? sext32(opb[31:0]) : {32'h0, opb[31:0]}) : opb;
  assign dsigned = !f3[0];
  assign ua = (dsigned && ma[63]) ? 64'h0 - ma : ma;
  assign ub = (dsigned && mb[63]) ? 64'h0 - mb : mb;
  assign na = dsigned && opa[63];
  assign nb = dsigned && opb[63];

  logic [64:0] msum;
  logic [65:0] ddiff;
  logic [63:0] mfin, dval, dq, dr;

  assign msum  = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, opa} : 65'h0);
  assign ddiff = {1'b0, acc_hi, acc_lo[63]} - {2'b00, dv};
  assign mfin  = (f3 == 3'd0) ? acc_lo
               : acc_hi - ((opb[63] && f3 == 3'd1) ? opa : 64'h0);
  assign dq    = ((na ^ nb) && (opb != 64'h0)) ? 64'h0 - acc_lo : acc_lo;
  assign dr    = na ? 64'h0 - acc_hi : acc_hi;
  assign dval  = f3[1] ? dr : dq;

  logic [1:0] fbyte;
  logic [2:0] lbyte;
  assign fbyte = 2'(cnt - 4'd1);
  assign lbyte = 3'(cnt - 4'd1);

  // Memory port muxing.
  assign mem_we    = cmd.clear || cmd.mem_wr || cmd.store;
  assign mem_waddr = cmd.clear ? clr : (cmd.mem_wr ? addr_q : ea + AW'(cnt));
  assign mem_wdata = cmd.clear ? 8'h00
                   : (cmd.mem_wr ? wbyte_q : opb[{cnt[2:0], 3'b000} +: 8]);
  assign mem_raddr = cmd.fetch ? pc[AW-1:0] + AW'(cnt)
                   : (cmd.load ? ea + AW'(cnt) : addr_q);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  assign rf_raddr = cmd.rd_rs2 ? rs2 : rs1;
  assign rf_we    = cmd.finish && have && (rd != 5'd0);
  assign rf_out   = rf_v ? rf_raw : 64'h0;

  always_ff @(posedge clk) begin
    if (rf_we) rf[rd] <= res;
    rf_raw <= rf[rf_raddr];
    rf_v   <= rf_valid[rf_raddr];
  end

  // Control registers and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      clr      <= '0;
      pc       <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear) clr <= clr + AW'(1);
      if (rf_we) rf_valid[rd] <= 1'b1;
      if (cmd.finish) pc <= npc;
    end
  end

  // Payload and sequencing registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q   <= req_type;
      addr_q  <= AW'(mem_address);
      wbyte_q <= write_byte;
      cnt     <= '0;
      have    <= 1'b0;
      illegal <= 1'b0;
      rbyte   <= '0;
      res     <= '0;
      npc     <= pc;
    end
    if (cmd.cap_rbyte) rbyte <= mem_rdata;
    if (cmd.fetch) begin
      if (cnt != 4'd0) ir[{fbyte, 3'b000} +: 8] <= mem_rdata;
      cnt <= cnt + 4'd1;
    end
    if (cmd.rd_rs2) opa <= rf_out;
    if (cmd.cap_b)  opb <= rf_out;
    if (cmd.exec) begin
      npc     <= pc + 64'd4;
      res     <= '0;
      have    <= 1'b0;
      illegal <= 1'b0;
      cnt     <= '0;
      lcnt    <= '0;
      case (cls)
        C_LUI: begin
          res  <= imm_u;
          have <= 1'b1;
        end
        C_AUIPC: begin
          res  <= pc + imm_u;
          have <= 1'b1;
        end
        C_JAL: begin
          res  <= pc + 64'd4;
          have <= 1'b1;
          npc  <= pc + imm_j;
        end
        C_JALR: begin
          res  <= pc + 64'd4;
          have <= 1'b1;
          npc  <= (opa + imm_i) & ~64'h1;
        end
        C_BRANCH: begin
          if (taken) npc <= pc + imm_b;
        end
        C_LOAD: begin
          have <= (f3 != F3_LOAD_RSVD);
          ea   <= AW'(opa + imm_i);
        end
        C_STORE: ea <= AW'(opa + imm_s);
        C_ALU: begin
          res  <= alu_r;
          have <= 1'b1;
        end
        C_MUL: begin
          opa    <= ma;
          opb    <= mb;
          acc_lo <= mb;
          acc_hi <= '0;
          have   <= 1'b1;
        end
        C_DIV: begin
          opa    <= ma;
          opb    <= mb;
          acc_lo <= ua;
          dv     <= ub;
          acc_hi <= '0;
          have   <= 1'b1;
        end
        default: illegal <= 1'b1;
      endcase
    end
    if (cmd.load) begin
      if (cnt != 4'd0) res[{lbyte, 3'b000} +: 8] <= mem_rdata;
      cnt <= cnt + 4'd1;
    end
    if (cmd.load_ext) begin
      case (f3)
        3'd0:    res <= {{56{res[7]}}, res[7:0]};
        3'd1:    res <= {{48{res[15]}}, res[15:0]};
        3'd2:    res <= sext32(res[31:0]);
        default: res <= res;
      endcase
    end
    if (cmd.store) cnt <= cnt + 4'd1;
    if (cmd.mstep) begin
      acc_hi <= msum[64:1];
      acc_lo <= {msum[0], acc_lo[63:1]};
      lcnt   <= lcnt + 6'd1;
    end
    if (cmd.mfix1) begin
      acc_hi <= acc_hi - ((opa[63] && (f3 == 3'd1 || f3 == 3'd2)) ? opb : 64'h0);
    end
    if (cmd.mfix2) res <= word ? sext32(mfin[31:0]) : mfin;
    if (cmd.dstep) begin
      acc_hi <= ddiff[65] ? {acc_hi[62:0], acc_lo[63]} : ddiff[63:0];
      acc_lo <= {acc_lo[62:0], !ddiff[65]};
      lcnt   <= lcnt + 6'd1;
    end
    if (cmd.dfix) res <= word ? sext32(dval[31:0]) : dval;
    if (cmd.finish) begin
      read_byte      <= (req_q == REQ_READ) ? rbyte : 8'h00;
      pc_value       <= npc;
      reg_written    <= have && (rd != 5'd0);
      reg_index      <= (have && rd != 5'd0) ? rd : 5'd0;
      reg_value      <= (have && rd != 5'd0) ? res : 64'h0;
      opcode_illegal <= illegal;
    end
  end

  assign st.cls       = cls;
  assign st.f3        = f3;
  assign st.cnt       = cnt;
  assign st.nbytes    = 4'd1 << f3[1:0];
  assign st.loop_last = &lcnt;
  assign st.clr_last  = &clr;

endmodule

// ===== rtl/rv64im_instruction_core_top.sv =====
// Top level of the RV64IM instruction core: controller plus datapath.
// Depends on rv64c_pkg, rv64c_ctrl and rv64c_dp.
//
//  Channel   Direction  Handshake          Fields
//  -------   ---------  -----------------  --------------------------------------
//  request   in         start & !busy      req_type, mem_address, write_byte
//  result    out        done (one cycle)   read_byte, pc_value, reg_written,
//                                          reg_index, reg_value, opcode_illegal
//
// A request transfer happens on a clock edge where start is high and busy is
// low. Exactly one result transfer follows each request, with done high for a
// single cycle. An instruction passes through the fetch of four bytes over the
// single memory read port, the two register file reads, execute and the final
// step; an n-byte load adds its n byte reads and an extension step, an n-byte
// store its n byte writes, a multiply a shift-add loop (one bit per cycle)
// and a divide or remainder a restoring loop (one bit per cycle). After reset
// the memory is cleared one byte per cycle, so busy stays high until the clear
// is complete and the first request can be taken.
// The receiver cannot stall: the result registers hold the last result and
// done marks the single cycle in which it is transferred.
module rv64im_instruction_core_top
  import rv64c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [7:0]  write_byte,
  output logic        done,
  output logic [7:0]  read_byte,
  output logic [63:0] pc_value,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [63:0] reg_value,
  output logic        opcode_illegal
);

  // Commands from the controller and status back from the datapath.
  cmd_t    cmd;
  status_t st;

  rv64c_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath captures the request fields on the accepting edge and
  // drives the result registers on the final step of each request.
  rv64c_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .mem_address    (mem_address),
    .write_byte     (write_byte),
    .st             (st),
    .done           (done),
    .read_byte      (read_byte),
    .pc_value       (pc_value),
    .reg_written    (reg_written),
    .reg_index      (reg_index),
    .reg_value      (reg_value),
    .opcode_illegal (opcode_illegal)
  );

endmodule

// ===== rtl/rv64c_checker.sv =====
// Port-level assertions for the RV64IM instruction core.
// Bound to rv64im_instruction_core_top; sees only its ports.
module rv64c_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        reg_written,
  input logic [4:0]  reg_index,
  input logic [63:0] reg_value
);

  // An accepted request always keeps the core busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("core not busy after a request transfer");

  // A result is only shown once the core has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    done && !reg_written |-> reg_index == 5'd0 && reg_value == 64'h0)
    else $error("register fields set without a register write");

  a_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && reg_written |-> reg_index != 5'd0)
    else $error("register write reported for x0");

endmodule

bind rv64im_instruction_core_top rv64c_checker u_checker (.*);

// ===== tb/rv64im_instruction_core_top_test.sv =====
// Self-checking testbench for the RV64IM instruction core top level.
// Depends on rv64c_pkg and the rv64im_instruction_core_top RTL only.
`timescale 1ns / 1ps

module rv64im_instruction_core_top_test;
  import rv64c_pkg::*;

  // Request code that the core must treat as a no-op.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Function codes used by the shadow core.
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
  localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LD = 3'd3;
  localparam logic [2:0] F3_LBU = 3'd4, F3_LHU = 3'd5, F3_LWU = 3'd6;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    logic [7:0]  rbyte;
    logic [63:0] pc;
    logic        wr;
    logic [4:0]  idx;
    logic [63:0] val;
    logic        ill;
  } core_result_t;

  typedef struct {
    logic [1:0]   req;
    logic [15:0]  addr;
    logic [7:0]   data;
    bit           typed;   // expected result written out in the row
    core_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_WRITE;
  logic [15:0] mem_address = '0;
  logic [7:0]  write_byte = '0;
  logic        busy, done;
  logic [7:0]  read_byte;
  logic [63:0] pc_value;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [63:0] reg_value;
  logic        opcode_illegal;

  rv64im_instruction_core_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .mem_address(mem_address), .write_byte(write_byte),
    .done(done), .read_byte(read_byte), .pc_value(pc_value),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
    .opcode_illegal(opcode_illegal)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the architectural state.
  logic [7:0]   shadow_mem [0:MEM_BYTES-1];
  logic [63:0]  shadow_regs [0:31];
  logic [63:0]  shadow_pc;
  core_result_t pending_results[$];
  int           error_count = 0;
  bit           quiet_stretch = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [63:0] load_bytes(input logic [63:0] addr, input int n);
    logic [63:0] v;
    logic [15:0] a;
    v = '0;
    for (int i = 0; i < n; i++) begin
      a = addr[15:0] + 16'(i);
      v[8*i +: 8] = shadow_mem[a];
    end
    return v;
  endfunction

  function automatic logic [63:0] sdiv64(input logic [63:0] a, input logic [63:0] b);
    if (b == '0) return '1;
    if (a == MIN64 && b == '1) return MIN64;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [63:0] srem64(input logic [63:0] a, input logic [63:0] b);
    if (b == '0) return a;
    if (a == MIN64 && b == '1) return '0;
    return $signed(a) % $signed(b);
  endfunction

  function automatic logic [63:0] alu64(input logic [63:0] a, input logic [63:0] b,
                                        input logic [2:0] f3, input bit md, input bit alt);
    logic [127:0] p;
    logic [5:0]   sh;
    sh = b[5:0];
    if (md) begin
      case (f3)
        F3_MUL:    return a * b;
        F3_MULH: begin
          p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
          return p[127:64];
        end
        F3_MULHSU: begin
          p = {{64{a[63]}}, a} * {64'b0, b};
          return p[127:64];
        end
        F3_MULHU: begin
          p = {64'b0, a} * {64'b0, b};
          return p[127:64];
        end
        F3_DIV:    return sdiv64(a, b);
        F3_DIVU:   return (b == '0) ? '1 : a / b;
        F3_REM:    return srem64(a, b);
        default:   return (b == '0) ? a : a % b;
      endcase
    end
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return 64'($signed(a) < $signed(b));
      F3_SLTU: return 64'(a < b);
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 64'($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [63:0] alu32(input logic [63:0] a, input logic [63:0] b,
                                        input logic [2:0] f3, input bit md, input bit alt);
    logic [63:0] sa, sb, za, zb, r;
    sa = sext32(a[31:0]);
    sb = sext32(b[31:0]);
    za = {32'b0, a[31:0]};
    zb = {32'b0, b[31:0]};
    if (md) begin
      case (f3)
        F3_MUL:  r = sa * sb;
        F3_DIV:  r = sdiv64(sa, sb);
        F3_DIVU: r = (zb == '0) ? '1 : za / zb;
        F3_REM:  r = srem64(sa, sb);
        F3_REMU: r = (zb == '0) ? za : za % zb;
        default: r = alu64(za, zb, f3, 1'b1, 1'b0);
      endcase
    end else begin
      case (f3)
        F3_ADD:  r = alt ? sa - sb : sa + sb;
        F3_SLL:  r = za << b[4:0];
        F3_SR:   r = alt ? 64'($signed(sa) >>> b[4:0]) : za >> b[4:0];
        default: r = alu64(za, zb, f3, 1'b0, alt);
      endcase
    end
    return sext32(r[31:0]);
  endfunction

  function automatic bit branch_taken(input logic [63:0] a, input logic [63:0] b,
                                      input logic [2:0] f3);
    case (f3)
      F3_BEQ:  return a == b;
      F3_BNE:  return a != b;
      F3_BLT:  return $signed(a) < $signed(b);
      F3_BGE:  return !($signed(a) < $signed(b));
      F3_BLTU: return a < b;
      F3_BGEU: return a >= b;
      default: return 1'b0;
    endcase
  endfunction

  // Executes the instruction at the shadow PC and fills in the result.
  task automatic run_instruction(inout core_result_t r);
    logic [31:0] raw;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, nxt, res, ad, lv;
    logic [15:0] sa;
    bit          have;
    raw   = 32'(load_bytes(shadow_pc, FETCH_BYTES));
    op    = raw[6:0];
    rd    = raw[11:7];
    f3    = raw[14:12];
    f7    = raw[31:25];
    a     = shadow_regs[raw[19:15]];
    b     = shadow_regs[raw[24:20]];
    imm_i = {{52{raw[31]}}, raw[31:20]};
    imm_s = {{52{raw[31]}}, raw[31:25], raw[11:7]};
    imm_b = {{51{raw[31]}}, raw[31], raw[7], raw[30:25], raw[11:8], 1'b0};
    imm_j = {{43{raw[31]}}, raw[31], raw[19:12], raw[20], raw[30:21], 1'b0};
    imm_u = sext32({raw[31:12], 12'b0});
    nxt   = shadow_pc + 64'd4;
    res   = '0;
    have  = 1'b0;
    case (op)
      OPC_LUI:   begin res = imm_u; have = 1'b1; end
      OPC_AUIPC: begin res = shadow_pc + imm_u; have = 1'b1; end
      OPC_JAL:   begin res = shadow_pc + 64'd4; have = 1'b1; nxt = shadow_pc + imm_j; end
      OPC_JALR: begin
        res = shadow_pc + 64'd4;
        have = 1'b1;
        nxt = (a + imm_i) & ~64'd1;
      end
      OPC_BRANCH: if (branch_taken(a, b, f3)) nxt = shadow_pc + imm_b;
      OPC_LOAD: begin
        ad = a + imm_i;
        lv = load_bytes(ad, 8);
        have = 1'b1;
        case (f3)
          F3_LB:   res = {{56{lv[7]}}, lv[7:0]};
          F3_LH:   res = {{48{lv[15]}}, lv[15:0]};
          F3_LW:   res = sext32(lv[31:0]);
          F3_LD:   res = lv;
          F3_LBU:  res = {56'h0, lv[7:0]};
          F3_LHU:  res = {48'h0, lv[15:0]};
          F3_LWU:  res = {32'h0, lv[31:0]};
          default: have = 1'b0;
        endcase
      end
      OPC_STORE:
        if (f3 < 3'd4) begin
          ad = a + imm_s;
          for (int i = 0; i < (1 << f3); i++) begin
            sa = ad[15:0] + 16'(i);
            shadow_mem[sa] = b[8*i +: 8];
          end
        end
      OPC_OPIMM: begin
        res = alu64(a, imm_i, f3, 1'b0, f3 == F3_SR && raw[31:26] == SRAI_HI);
        have = 1'b1;
      end
      OPC_OP: begin
        res = alu64(a, b, f3, f7 == F7_MULDIV, f7 == F7_ALT);
        have = 1'b1;
      end
      OPC_OPIMM32: begin
        res = alu32(a, imm_i, f3, 1'b0, f3 == F3_SR && f7 == F7_ALT);
        have = 1'b1;
      end
      OPC_OP32: begin
        res = alu32(a, b, f3, f7 == F7_MULDIV, f7 == F7_ALT);
        have = 1'b1;
      end
      default: r.ill = 1'b1;
    endcase
    if (have && rd != 5'd0) begin
      shadow_regs[rd] = res;
      r.wr  = 1'b1;
      r.idx = rd;
      r.val = res;
    end
    shadow_pc = nxt;
  endtask

  // Applies one accepted request to the shadow state and returns its result.
  task automatic retire_request(input logic [1:0] req, input logic [15:0] addr,
                                input logic [7:0] data, output core_result_t r);
    r = '{rbyte: 8'h0, pc: 64'h0, wr: 1'b0, idx: 5'h0, val: 64'h0, ill: 1'b0};
    case (req)
      REQ_WRITE: shadow_mem[addr] = data;
      REQ_READ:  r.rbyte = shadow_mem[addr];
      REQ_EXEC:  run_instruction(r);
      default: ;
    endcase
    r.pc = shadow_pc;
  endtask

  // Drives one request and holds it until the core takes it. The sender
  // sometimes idles afterwards, with start low.
  task automatic send_request(input logic [1:0] req, input logic [15:0] addr,
                              input logic [7:0] data, input bit typed,
                              input core_result_t typed_res);
    core_result_t r;
    start       <= 1'b1;
    req_type    <= req;
    mem_address <= addr;
    write_byte  <= data;
    do @(posedge clk); while (busy);
    retire_request(req, addr, data, r);
    pending_results.push_back(typed ? typed_res : r);
    if (!quiet_stretch && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Random instruction word, biased toward recognized opcodes with
  // interesting function fields and immediates.
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    logic [6:0]  ops [11];
    ops = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
            OPC_OPIMM, OPC_OP, OPC_OPIMM32, OPC_OP32};
    w = $urandom;
    if ($urandom_range(99) < 6) begin
      w[6:0] = 7'($urandom);
    end else begin
      w[6:0] = ops[$urandom_range(10)];
      // ALU work dominates so registers fill with varied values.
      if ($urandom_range(99) < 40)
        w[6:0] = ops[$urandom_range(10, 7)];
    end
    // Keep most sources on a few registers so results feed back.
    if ($urandom_range(3) != 0) begin
      w[19:15] = 5'($urandom_range(7));
      w[24:20] = 5'($urandom_range(7));
    end
    case (w[6:0])
      OPC_OP, OPC_OP32:
        case ($urandom_range(3))
          0: w[31:25] = 7'h00;
          1: w[31:25] = F7_MULDIV;
          2: w[31:25] = F7_ALT;
          default: ;
        endcase
      OPC_OPIMM: begin
        if (w[14:12] == F3_SR && $urandom_range(1)) w[31:26] = SRAI_HI;
        if ($urandom_range(7) == 0) w[31:20] = $urandom_range(1) ? 12'hFFF : 12'h800;
      end
      OPC_OPIMM32: if ($urandom_range(1)) w[31:25] = $urandom_range(1) ? F7_ALT : 7'h00;
      OPC_JALR: if ($urandom_range(1)) w[31:20] = 12'(8 * $urandom_range(4));
      default: ;
    endcase
    return w;
  endfunction

  // Results leave the core for one cycle each; compare against the oldest
  // expectation as they appear.
  always @(posedge clk) begin
    core_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 64'(done), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (read_byte !== want.rbyte)
          report_mismatch("read_byte", 64'(read_byte), 64'(want.rbyte));
        if (pc_value !== want.pc)       report_mismatch("pc_value", pc_value, want.pc);
        if (reg_written !== want.wr)
          report_mismatch("reg_written", 64'(reg_written), 64'(want.wr));
        if (reg_index !== want.idx)
          report_mismatch("reg_index", 64'(reg_index), 64'(want.idx));
        if (reg_value !== want.val)     report_mismatch("reg_value", reg_value, want.val);
        if (opcode_illegal !== want.ill)
          report_mismatch("opcode_illegal", 64'(opcode_illegal), 64'(want.ill));
      end
    end
  end

  // Run limit: the memory clear after reset plus the time for every request,
  // taken many times over.
  initial begin
    #40_000_000;
    $display("rv64im_instruction_core_top test failed");
    $finish;
  end

  initial begin
    stim_row_t    rows [$];
    core_result_t z;
    logic [31:0]  word;
    int           sent;
    z = '{rbyte: 8'h0, pc: 64'h0, wr: 1'b0, idx: 5'h0, val: 64'h0, ill: 1'b0};
    for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = 8'h0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = 64'h0;
    shadow_pc = 64'h0;

    // Directed table. Rows with typed results are readable straight from the
    // reset state; the rest go through the shadow core.
    rows.push_back('{REQ_READ,  16'h0000, 8'h00, 1, z});
    rows.push_back('{REQ_READ,  16'hFFFF, 8'hFF, 1, z});
    rows.push_back('{REQ_WRITE, 16'hFFFF, 8'hFF, 1, z});
    rows.push_back('{REQ_READ,  16'hFFFF, 8'h00, 1, '{8'hFF, 64'h0, 1'b0, 5'h0, 64'h0, 1'b0}});
    rows.push_back('{REQ_NONE,  16'hFFFF, 8'hFF, 1, z});
    rows.push_back('{REQ_WRITE, 16'h0000, 8'h5A, 1, z});
    rows.push_back('{REQ_READ,  16'h0000, 8'h00, 1, '{8'h5A, 64'h0, 1'b0, 5'h0, 64'h0, 1'b0}});
    // Unknown opcode at address 0 skips four bytes.
    rows.push_back('{REQ_EXEC,  16'h0000, 8'h00, 1, '{8'h00, 64'h4, 1'b0, 5'h0, 64'h0, 1'b1}});
    // LUI x1 with the largest upper immediate at address 4.
    rows.push_back('{REQ_WRITE, 16'h0004, 8'hB7, 0, z});
    rows.push_back('{REQ_WRITE, 16'h0005, 8'hF0, 0, z});
    rows.push_back('{REQ_WRITE, 16'h0006, 8'hFF, 0, z});
    rows.push_back('{REQ_WRITE, 16'h0007, 8'hFF, 0, z});
    rows.push_back('{REQ_EXEC,  16'h0000, 8'h00, 0, z});
    // Cleared memory after that decodes as an unknown opcode again.
    rows.push_back('{REQ_EXEC,  16'h1234, 8'hA5, 1, '{8'h00, 64'hC, 1'b0, 5'h0, 64'h0, 1'b1}});
    rows.push_back('{REQ_READ,  16'h0005, 8'h00, 0, z});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_request(rows[i].req, rows[i].addr, rows[i].data, rows[i].typed, rows[i].res);

    // Random part: mostly an instruction written at the PC and executed,
    // with stray reads, writes, no-op requests and bare executes mixed in.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet_stretch = (sent >= 300 && sent < 500);
      if (sent >= 650 && sent < 660) begin
        // Hold the sender until the core has drained every result.
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if ($urandom_range(99) < 75) begin
        word = random_instruction();
        for (int i = 0; i < 4; i++)
          send_request(REQ_WRITE, shadow_pc[15:0] + 16'(i), word[8*i +: 8], 0, z);
        send_request(REQ_EXEC, 16'($urandom), 8'($urandom), 0, z);
        sent += 5;
      end else begin
        send_request(2'($urandom), 16'($urandom), 8'($urandom), 0, z);
        sent++;
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("rv64im_instruction_core_top test passed");
    else
      $display("rv64im_instruction_core_top test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rv64c_pkg.sv
rtl/rv64c_ctrl.sv
rtl/rv64c_dp.sv
rtl/rv64im_instruction_core_top.sv
rtl/rv64c_checker.sv
tb/rv64im_instruction_core_top_test.sv
